### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the dispatcher checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define TQSJD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define TQSJD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tqsjd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher package
// Sizes, codes and shared types of the two-queue shortest-join dispatcher.
// ----------------------------------------------------------------------------
package tqsjd_pkg;

   // Sizing
   localparam int ID_COUNT    = 1024;
   localparam int QUEUE_DEPTH = 1024;
   localparam int ID_W        = 10;
   localparam int MAP_AW      = $clog2(ID_COUNT);
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int PTR_W       = SLOT_W + 1;
   localparam int LC_W        = $clog2(QUEUE_DEPTH + 1);

   // Pointer wrap point and ring depth at one bit above pointer width
   localparam logic [PTR_W:0] PTR_WRAP  = (PTR_W + 1)'(2 * QUEUE_DEPTH);
   localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);

   // Request operations
   typedef enum logic [1:0] {
      OP_SERVE0 = 2'd0,
      OP_SERVE1 = 2'd1,
      OP_ARRIVE = 2'd2,
      OP_LEAVE  = 2'd3
   } op_type;

   // Response status codes
   typedef enum logic [1:0] {
      ST_SERVED   = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_ASSIGNED = 2'd2,
      ST_REJECTED = 2'd3
   } status_type;

   // Operations of the shared arithmetic unit
   typedef enum logic [2:0] {
      UOP_PTR_NEXT = 3'd0,
      UOP_OCC_FULL = 3'd1,
      UOP_LESS     = 3'd2,
      UOP_INC      = 3'd3,
      UOP_DEC_SAT  = 3'd4
   } uop_type;

   typedef struct packed {
      logic              valid;
      logic              queue;
      logic [SLOT_W-1:0] slot;
   } map_entry_type;

   typedef struct packed {
      uop_type          op;
      logic [PTR_W-1:0] a;
      logic [PTR_W-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic [PTR_W-1:0] value;
      logic             flag;
   } unit_rsp_type;

   typedef struct packed {
      op_type          op;
      logic [ID_W-1:0] item_id;
   } request_type;

   typedef struct packed {
      logic            valid;
      status_type      status;
      logic [ID_W-1:0] value;
   } result_type;

endpackage

### src/tqsjd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher channels
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface tqsjd_req_if import tqsjd_pkg::*; ();
   logic            valid;
   logic            ready;
   op_type          op;
   logic [ID_W-1:0] item_id;

   modport source (output valid, output op, output item_id, input ready);
   modport sink   (input valid, input op, input item_id, output ready);
endinterface

interface tqsjd_rsp_if import tqsjd_pkg::*; ();
   logic            valid;
   logic            ready;
   status_type      status;
   logic [ID_W-1:0] value;

   modport source (output valid, output status, output value, input ready);
   modport sink   (input valid, input status, input value, output ready);
endinterface

### src/two_queue_shortest_join_dispatcher_core.sv
`timescale 1ns / 1ps
// One request at a time. A serve or arrival steps through its states to a response;
// an empty serve, a duplicate-id arrival and a full-ring rejection end early. A leave
// gives no response. Each stale head slot skipped by a serve adds a pass through the test,
// slot and map states. Synchronous reset zeroes pointers and counts, then sweeps all
// ID_COUNT entries of the location map to invalid; no request is taken during the sweep.
// ----------------------------------------------------------------------------
// Two-queue shortest-join dispatcher
// Top level: request channel, sequencer with shared unit, response register.
// ----------------------------------------------------------------------------
module two_queue_shortest_join_dispatcher_core import tqsjd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tqsjd_req_if.sink   req_ch,
   tqsjd_rsp_if.source rsp_ch
);

   request_type  req_pl;
   result_type   res;
   logic         res_take;
   logic         seq_ready;
   unit_req_type unit_req;
   unit_rsp_type unit_rsp;

   logic            rsp_valid_ff;
   status_type      rsp_status_ff;
   logic [ID_W-1:0] rsp_value_ff;

   assign req_pl.op      = req_ch.op;
   assign req_pl.item_id = req_ch.item_id;
   assign req_ch.ready   = seq_ready;

   tqsjd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req       (req_pl),
      .req_ready (seq_ready),
      .res       (res),
      .res_take  (res_take),
      .unit_req  (unit_req),
      .unit_rsp  (unit_rsp)
   );

   tqsjd_unit u_unit (
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   // Take a finished result whenever the output stage is free or draining
   assign res_take = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (res.valid && res_take) begin
         rsp_status_ff <= res.status;
         rsp_value_ff  <= res.value;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.value  = rsp_value_ff;

endmodule

### src/tqsjd_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Pointer step, ring occupancy test, compare and counter step, one per cycle.
// ----------------------------------------------------------------------------
module tqsjd_unit import tqsjd_pkg::*; (
   input  unit_req_type unit_req,
   output unit_rsp_type unit_rsp
);

   logic [PTR_W:0] a_ext;
   logic [PTR_W:0] b_ext;
   logic [PTR_W:0] sum;
   logic [PTR_W:0] occ;

   always_comb begin
      a_ext    = {1'b0, unit_req.a};
      b_ext    = {1'b0, unit_req.b};
      sum      = a_ext + 1'b1;
      occ      = '0;
      unit_rsp = '0;
      unique case (unit_req.op)
         // advance a pointer, wrapping at twice the ring depth
         UOP_PTR_NEXT: begin
            unit_rsp.value = (sum >= PTR_WRAP) ? '0 : PTR_W'(sum);
         end
         // a is head, b is tail: flag when the ring holds a full depth
         UOP_OCC_FULL: begin
            occ           = (b_ext >= a_ext) ? (b_ext - a_ext) : (b_ext + PTR_WRAP - a_ext);
            unit_rsp.flag = (occ >= DEPTH_EXT);
         end
         UOP_LESS: begin
            unit_rsp.flag = (unit_req.a < unit_req.b);
         end
         UOP_INC: begin
            unit_rsp.value = PTR_W'(sum);
         end
         // count down, holding at zero
         UOP_DEC_SAT: begin
            unit_rsp.value = (unit_req.a == '0) ? '0 : (unit_req.a - 1'b1);
         end
         default: begin
            unit_rsp = '0;
         end
      endcase
   end

endmodule

### src/tqsjd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher sequencer
// Owns the ring and location map memories and steps each request through
// the shared unit.
// ----------------------------------------------------------------------------
module tqsjd_seq import tqsjd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  request_type  req,
   output logic         req_ready,
   output result_type   res,
   input  logic         res_take,
   output unit_req_type unit_req,
   input  unit_rsp_type unit_rsp
);

   typedef enum logic [11:0] {
      S_CLEAR    = 12'b0000_0000_0001,
      S_IDLE     = 12'b0000_0000_0010,
      S_SRV_TEST = 12'b0000_0000_0100,
      S_SRV_SLOT = 12'b0000_0000_1000,
      S_SRV_MAP  = 12'b0000_0001_0000,
      S_SRV_POP  = 12'b0000_0010_0000,
      S_ARR_PICK = 12'b0000_0100_0000,
      S_ARR_FULL = 12'b0000_1000_0000,
      S_ARR_TAIL = 12'b0001_0000_0000,
      S_ARR_LIVE = 12'b0010_0000_0000,
      S_LEAVE    = 12'b0100_0000_0000,
      S_RESP     = 12'b1000_0000_0000
   } seq_state_type;

   localparam logic [MAP_AW-1:0] CLEAR_LAST = MAP_AW'(ID_COUNT - 1);

   function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] ptr);
      logic [PTR_W:0] wide;
      wide = {1'b0, ptr};
      if (wide >= DEPTH_EXT) begin
         return SLOT_W'(wide - DEPTH_EXT);
      end
      return SLOT_W'(wide);
   endfunction

   function automatic logic id_in_range(input logic [ID_W-1:0] id);
      logic [31:0] wide;
      wide = 32'(id);
      return (wide < 32'(ID_COUNT));
   endfunction

   // Memories
   logic [ID_W-1:0] slot_mem [2][QUEUE_DEPTH];
   map_entry_type   map_mem  [ID_COUNT];

   // Control and working registers
   seq_state_type   state_ff, state_in;
   logic [MAP_AW-1:0] clear_ff, clear_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic            queue_ff, queue_in;
   logic [PTR_W-1:0] head_ff [2];
   logic [PTR_W-1:0] head_in [2];
   logic [PTR_W-1:0] tail_ff [2];
   logic [PTR_W-1:0] tail_in [2];
   logic [LC_W-1:0]  live_ff [2];
   logic [LC_W-1:0]  live_in [2];
   status_type      status_ff, status_in;
   logic [ID_W-1:0] value_ff, value_in;
   logic [ID_W-1:0] slot_rd_ff;
   map_entry_type   map_rd_ff;

   // Memory port controls
   logic              map_we;
   logic [MAP_AW-1:0] map_waddr;
   map_entry_type     map_wdata;
   logic              map_re;
   logic [MAP_AW-1:0] map_raddr;
   logic              slot_we;
   logic              slot_re;

   // Views of the selected queue
   logic [PTR_W-1:0]  head_sel;
   logic [PTR_W-1:0]  tail_sel;
   logic [LC_W-1:0]   live_sel;
   logic [SLOT_W-1:0] head_slot;
   logic [SLOT_W-1:0] tail_slot;
   logic              head_live;

   assign head_sel  = head_ff[queue_ff];
   assign tail_sel  = tail_ff[queue_ff];
   assign live_sel  = live_ff[queue_ff];
   assign head_slot = slot_of(head_sel);
   assign tail_slot = slot_of(tail_sel);
   assign head_live = map_rd_ff.valid && (map_rd_ff.queue == queue_ff)
                      && (map_rd_ff.slot == head_slot);

   assign req_ready  = (state_ff == S_IDLE);
   assign res.valid  = (state_ff == S_RESP);
   assign res.status = status_ff;
   assign res.value  = value_ff;

   // Sequencer next state and datapath selection
   always_comb begin
      state_in  = state_ff;
      clear_in  = clear_ff;
      id_in     = id_ff;
      queue_in  = queue_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      live_in   = live_ff;
      status_in = status_ff;
      value_in  = value_ff;
      unit_req  = '0;
      map_we    = 1'b0;
      map_waddr = MAP_AW'(id_ff);
      map_wdata = '0;
      map_re    = 1'b0;
      map_raddr = MAP_AW'(req.item_id);
      slot_we   = 1'b0;
      slot_re   = 1'b0;

      unique case (state_ff)
         // sweep the location map to invalid, one entry a cycle
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clear_ff;
            clear_in  = clear_ff + 1'b1;
            if (clear_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end
         end
         // take a request and look up its id in the map
         S_IDLE: begin
            if (req_valid) begin
               id_in    = req.item_id;
               queue_in = (req.op == OP_SERVE1);
               map_re   = 1'b1;
               unique case (req.op)
                  OP_SERVE0, OP_SERVE1: state_in = S_SRV_TEST;
                  OP_ARRIVE:            state_in = S_ARR_PICK;
                  OP_LEAVE:             state_in = S_LEAVE;
               endcase
            end
         end
         // empty ring ends the serve, otherwise read the head slot
         S_SRV_TEST: begin
            if (head_sel == tail_sel) begin
               status_in = ST_EMPTY;
               value_in  = '0;
               state_in  = S_RESP;
            end else begin
               slot_re  = 1'b1;
               state_in = S_SRV_SLOT;
            end
         end
         // look up the head id, or drop the slot if the id is out of range
         S_SRV_SLOT: begin
            if (id_in_range(slot_rd_ff)) begin
               map_re    = 1'b1;
               map_raddr = MAP_AW'(slot_rd_ff);
               state_in  = S_SRV_MAP;
            end else begin
               unit_req.op       = UOP_PTR_NEXT;
               unit_req.a        = head_sel;
               head_in[queue_ff] = unit_rsp.value;
               state_in          = S_SRV_TEST;
            end
         end
         // advance the head; unmap a live id, skip a stale slot
         S_SRV_MAP: begin
            unit_req.op       = UOP_PTR_NEXT;
            unit_req.a        = head_sel;
            head_in[queue_ff] = unit_rsp.value;
            if (head_live) begin
               map_we    = 1'b1;
               map_waddr = MAP_AW'(slot_rd_ff);
               state_in  = S_SRV_POP;
            end else begin
               state_in = S_SRV_TEST;
            end
         end
         S_SRV_POP: begin
            unit_req.op       = UOP_DEC_SAT;
            unit_req.a        = PTR_W'(live_sel);
            live_in[queue_ff] = LC_W'(unit_rsp.value);
            status_in         = ST_SERVED;
            value_in          = slot_rd_ff;
            state_in          = S_RESP;
         end
         // choose the queue with fewer live ids, ties to queue zero; reject an out-of-range or mapped id
         S_ARR_PICK: begin
            unit_req.op = UOP_LESS;
            unit_req.a  = PTR_W'(live_ff[1]);
            unit_req.b  = PTR_W'(live_ff[0]);
            queue_in    = unit_rsp.flag;
            if (!id_in_range(id_ff) || map_rd_ff.valid) begin
               status_in = ST_REJECTED;
               value_in  = '0;
               state_in  = S_RESP;
            end else begin
               state_in = S_ARR_FULL;
            end
         end
         // reject on a full ring, else store the id and map it
         S_ARR_FULL: begin
            unit_req.op = UOP_OCC_FULL;
            unit_req.a  = head_sel;
            unit_req.b  = tail_sel;
            if (unit_rsp.flag) begin
               status_in = ST_REJECTED;
               value_in  = '0;
               state_in  = S_RESP;
            end else begin
               slot_we         = 1'b1;
               map_we          = 1'b1;
               map_wdata.valid = 1'b1;
               map_wdata.queue = queue_ff;
               map_wdata.slot  = tail_slot;
               state_in        = S_ARR_TAIL;
            end
         end
         S_ARR_TAIL: begin
            unit_req.op       = UOP_PTR_NEXT;
            unit_req.a        = tail_sel;
            tail_in[queue_ff] = unit_rsp.value;
            state_in          = S_ARR_LIVE;
         end
         S_ARR_LIVE: begin
            unit_req.op       = UOP_INC;
            unit_req.a        = PTR_W'(live_sel);
            live_in[queue_ff] = LC_W'(unit_rsp.value);
            status_in         = ST_ASSIGNED;
            value_in          = ID_W'(queue_ff);
            state_in          = S_RESP;
         end
         // unmap a waiting id and drop its queue's live count
         S_LEAVE: begin
            if (id_in_range(id_ff) && map_rd_ff.valid) begin
               unit_req.op              = UOP_DEC_SAT;
               unit_req.a               = PTR_W'(live_ff[map_rd_ff.queue]);
               live_in[map_rd_ff.queue] = LC_W'(unit_rsp.value);
               map_we                   = 1'b1;
            end
            state_in = S_IDLE;
         end
         // hold the result until the output stage takes it
         S_RESP: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clear_ff <= '0;
         head_ff  <= '{default: '0};
         tail_ff  <= '{default: '0};
         live_ff  <= '{default: '0};
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         live_ff  <= live_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      queue_ff  <= queue_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   // Location map, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      if (map_re) begin
         map_rd_ff <= map_mem[map_raddr];
      end
   end

   // Ring slots, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[queue_ff][tail_slot] <= id_ff;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[queue_ff][head_slot];
      end
   end

endmodule

### src/tqsjd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher port checker
// Watches the top-level channels for response rules and the reset sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tqsjd_checker import tqsjd_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [1:0]      rsp_status,
   input logic [ID_W-1:0] rsp_value
);

   // Hold a stalled response
   `TQSJD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   `TQSJD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_value), "response changed while stalled")

   // An assignment names queue zero or one
   `TQSJD_ASSERT_NOW(a_assign_queue, clock, reset, rsp_valid && (rsp_status == ST_ASSIGNED), rsp_value[ID_W-1:1] == '0, "assignment names a queue other than zero or one")

   // Empty and rejected responses carry zero
   `TQSJD_ASSERT_NOW(a_zero_value, clock, reset, rsp_valid && ((rsp_status == ST_EMPTY) || (rsp_status == ST_REJECTED)), rsp_value == '0, "empty or rejected response with nonzero value")

   // The map sweep keeps requests out right after reset
   `TQSJD_ASSERT_NEXT(a_reset_busy, clock, 1'b0, reset, !req_ready, "request taken before the map sweep")

endmodule

bind two_queue_shortest_join_dispatcher_core tqsjd_checker u_tqsjd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_value  (rsp_ch.value)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher testbench
// Sends serve, arrive and leave requests to the two-queue shortest-join
// dispatcher over its valid/ready channels. A scoreboard keeps its own copy of
// both rings, the id location map, the pointers and the live counts. It
// predicts each response and checks responses field by field, in order. The
// run covers empty serves, stale head slots, duplicate arrivals and unknown
// leaves, and ends by draining both queues.
// ----------------------------------------------------------------------------
module tb_top;
   import tqsjd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 500;
   localparam int HOLD_AFTER    = 120;
   localparam int RANDOM_ITEMS  = 450;
   localparam int STEADY_ITEMS  = 150;
   localparam int HOT_IDS       = 48;

   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] value;
   } dispatch_response_type;

   // Mirror of the dispatcher state; predicts one response per serve or arrive request
   class dispatch_scoreboard;
      logic [ID_W-1:0]  ring_ids [2][QUEUE_DEPTH];
      map_entry_type    loc_map [ID_COUNT];
      logic [PTR_W-1:0] head_ptr [2];
      logic [PTR_W-1:0] tail_ptr [2];
      logic [LC_W-1:0]  live_cnt [2];
      dispatch_response_type pending_responses [$];
      int failures;
      int results_seen;

      function new();
         foreach (loc_map[i]) loc_map[i] = '0;
         foreach (ring_ids[q, s]) ring_ids[q][s] = '0;
         for (int q = 0; q < 2; q++) begin
            head_ptr[q] = '0;
            tail_ptr[q] = '0;
            live_cnt[q] = '0;
         end
         failures     = 0;
         results_seen = 0;
      endfunction

      function int ring_fill(bit q);
         logic [PTR_W-1:0] occ;
         occ = tail_ptr[q] - head_ptr[q];
         return int'(occ);
      endfunction

      function int live_of(bit q);
         return int'(live_cnt[q]);
      endfunction

      function int pending_count();
         return pending_responses.size();
      endfunction

      // A head slot counts only if its id still points back at this queue and slot
      function bit head_is_waiting(bit q);
         logic [SLOT_W-1:0] s;
         map_entry_type     m;
         s = head_ptr[q][SLOT_W-1:0];
         m = loc_map[ring_ids[q][s]];
         return m.valid && (m.queue == q) && (m.slot == s);
      endfunction

      function void note_request(op_type op, logic [ID_W-1:0] id);
         bit                    q;
         logic [SLOT_W-1:0]     s;
         logic [ID_W-1:0]       v;
         dispatch_response_type rsp;
         case (op)
            OP_SERVE0, OP_SERVE1: begin
               q = (op == OP_SERVE1);
               // Drop stale slots at the head
               while (head_ptr[q] != tail_ptr[q] && !head_is_waiting(q))
                  head_ptr[q] = head_ptr[q] + 1'b1;
               if (head_ptr[q] == tail_ptr[q]) begin
                  rsp = '{status: ST_EMPTY, value: '0};
               end else begin
                  s = head_ptr[q][SLOT_W-1:0];
                  v = ring_ids[q][s];
                  loc_map[v] = '0;
                  head_ptr[q] = head_ptr[q] + 1'b1;
                  if (live_cnt[q] != 0) live_cnt[q] = live_cnt[q] - 1'b1;
                  rsp = '{status: ST_SERVED, value: v};
               end
               pending_responses.push_back(rsp);
            end
            OP_ARRIVE: begin
               q = (live_cnt[1] < live_cnt[0]);
               if (loc_map[id].valid || ring_fill(q) >= QUEUE_DEPTH) begin
                  rsp = '{status: ST_REJECTED, value: '0};
               end else begin
                  s = tail_ptr[q][SLOT_W-1:0];
                  ring_ids[q][s] = id;
                  tail_ptr[q] = tail_ptr[q] + 1'b1;
                  loc_map[id] = '{valid: 1'b1, queue: q, slot: s};
                  live_cnt[q] = live_cnt[q] + 1'b1;
                  rsp = '{status: ST_ASSIGNED, value: ID_W'(q)};
               end
               pending_responses.push_back(rsp);
            end
            default: begin
               // Leave: unmap a waiting id, otherwise nothing happens
               if (loc_map[id].valid) begin
                  q = loc_map[id].queue;
                  if (live_cnt[q] != 0) live_cnt[q] = live_cnt[q] - 1'b1;
                  loc_map[id] = '0;
               end
            end
         endcase
      endfunction

      task report(string msg);
         failures++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_response(status_type status, logic [ID_W-1:0] value);
         dispatch_response_type exp;
         results_seen++;
         if (pending_responses.size() == 0) begin
            report($sformatf("response %0d with nothing expected (status %0d value %0d)",
                             results_seen, status, value));
         end else begin
            exp = pending_responses.pop_front();
            if (status !== exp.status)
               report($sformatf("response %0d status %0d, want %0d",
                                results_seen, status, exp.status));
            if (value !== exp.value)
               report($sformatf("response %0d value %0d, want %0d",
                                results_seen, value, exp.value));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   idle_pct = 7;
   int   cycle_count = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;

   dispatch_scoreboard sb = new();

   tqsjd_req_if req_if ();
   tqsjd_rsp_if rsp_if ();

   two_queue_shortest_join_dispatcher_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Offer one request and hold it until the block takes it
   task automatic send_request(op_type op, logic [ID_W-1:0] id);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.op      <= op;
      req_if.item_id <= id;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(op, id);
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 99) < 75) return ID_W'($urandom_range(0, HOT_IDS - 1));
      return ID_W'($urandom_range(0, ID_COUNT - 1));
   endfunction

   function automatic op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return OP_ARRIVE;
      if (r < 65) return OP_LEAVE;
      if (r < 82) return OP_SERVE0;
      return OP_SERVE1;
   endfunction

   // Response side: check, idle at random, and hold off once for a long stretch
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.status, rsp_if.value);
         if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // Abort a run that hangs
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.op      <= OP_SERVE0;
      req_if.item_id <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty serves, unknown leave, extreme ids, duplicate, stale heads
      send_request(OP_SERVE0, 10'd0);
      send_request(OP_SERVE1, 10'd1023);
      send_request(OP_LEAVE,  10'd5);
      send_request(OP_ARRIVE, 10'd0);
      send_request(OP_ARRIVE, 10'd1023);
      send_request(OP_ARRIVE, 10'd0);
      send_request(OP_ARRIVE, 10'd682);
      send_request(OP_ARRIVE, 10'd341);
      send_request(OP_LEAVE,  10'd0);
      send_request(OP_LEAVE,  10'd0);
      send_request(OP_ARRIVE, 10'd7);
      send_request(OP_SERVE0, 10'd0);
      send_request(OP_SERVE0, 10'd0);
      send_request(OP_SERVE0, 10'd0);
      // Re-join the other queue, then the same queue at a new slot
      send_request(OP_LEAVE,  10'd1023);
      send_request(OP_ARRIVE, 10'd1023);
      send_request(OP_ARRIVE, 10'd9);
      send_request(OP_LEAVE,  10'd9);
      send_request(OP_ARRIVE, 10'd9);
      send_request(OP_SERVE0, 10'd0);
      send_request(OP_SERVE0, 10'd0);
      send_request(OP_SERVE1, 10'd0);
      send_request(OP_SERVE1, 10'd0);

      // Random traffic with light idling, then a stretch with none
      repeat (RANDOM_ITEMS) send_request(pick_op(), pick_id());
      idle_pct = 0;
      repeat (STEADY_ITEMS) send_request(pick_op(), pick_id());
      idle_pct = 7;

      // Drain both queues through whatever stale slots remain
      while (sb.live_of(0) != 0) send_request(OP_SERVE0, pick_id());
      while (sb.live_of(1) != 0) send_request(OP_SERVE1, pick_id());
      send_request(OP_SERVE0, 10'd0);
      send_request(OP_SERVE1, 10'd0);
      req_if.valid <= 1'b0;

      // Wait for every response, then a little longer for strays
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending_count() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
